[hdl/sma_pkg.sv]
// ----------------------------------------------------------------------------
// sma_pkg - shared types and codes for the stack machine ALU
// Command, status and word types used by the sequencer and the divider.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned COUNT_W = 9;

    typedef enum logic [3:0] {
        CMD_PUSH = 4'd0,
        CMD_POP  = 4'd1,
        CMD_SWAP = 4'd2,
        CMD_DUP  = 4'd3,
        CMD_ADD  = 4'd4,
        CMD_SUB  = 4'd5,
        CMD_MUL  = 4'd6,
        CMD_DIV  = 4'd7,
        CMD_CMP  = 4'd8,
        CMD_NEG  = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [63:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] top_value;
        logic [8:0]         stack_count;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WR,
        S_WR2,
        S_RDT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

[hdl/sma_div.sv]
// ----------------------------------------------------------------------------
// sma_div - signed 64-bit divider
// Restoring division, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sma_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sma_pkg::t_div_req i_req,
    output sma_pkg::t_div_rsp o_rsp
);
    import sma_pkg::*;

    logic [63:0] r_q, n_q;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [64:0] w_trial;
    logic [64:0] w_shift;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_done = 1'b0;
        w_shift = {r_rem, r_q[63]};
        w_trial = w_shift - {1'b0, r_den};
        if (i_req.start) begin
            n_q    = i_req.num[63] ? (64'd0 - i_req.num) : i_req.num;
            n_den  = i_req.den[63] ? (64'd0 - i_req.den) : i_req.den;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
            n_neg  = i_req.num[63] ^ i_req.den[63];
        end else if (r_busy) begin
            // shift in one numerator bit, subtract when it fits
            if (!w_trial[64]) begin
                n_rem = w_trial[63:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_shift[63:0];
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? (64'd0 - r_q) : r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider did not start");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held two cycles");

endmodule

[hdl/stack_machine_alu.sv]
// ----------------------------------------------------------------------------
// stack_machine_alu - 64-bit data stack with an integer execute unit
// Stack entries live in a synchronous RAM; a sequencer reads, computes and
// writes back one command word at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  i_in    | in        | i_in_valid/o_in_ready | cmd, push_value
//  o_out   | out       | o_out_valid/i_out_ready | top_value, stack_count, status
//
//  One command at a time. After the accepting state push runs S_WR, pop and
//  unused codes S_RDT, dup and neg S_RD1, S_EXEC, S_WR, add, sub and cmp S_RD1,
//  S_RD2, S_EXEC, S_WR; swap adds S_WR2, multiply S_MUL for its split partial
//  products and divide S_DIV for the bit-serial divider loop, all then S_OUT.
//  Underflow and overflow go straight to S_OUT, divide by zero after S_EXEC.
//  Each read goes through the registered RAM read port, which sets the read states.
//  Reset clears state, pointer and mul phase; unwritten RAM never reaches the output.
//  A result held by a stalled output keeps the block from taking the next word.
module stack_machine_alu #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sma_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sma_pkg::t_out_word o_out
);
    import sma_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_wdata;

    t_state      r_state, n_state;
    logic [PW-1:0] r_sp, n_sp;
    logic [3:0]  r_cmd, n_cmd;
    logic [63:0] r_val, n_val;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_res, n_res;
    logic [63:0] r_p0, n_p0;
    logic [63:0] r_p1, n_p1;
    logic [1:0]  r_status, n_status;
    logic [63:0] r_top, n_top;
    logic        r_mulph, n_mulph;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;
    logic [63:0] w_bx, w_ax;

    sma_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // synchronous RAM, one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    assign w_bx = r_b ^ 64'h8000_0000_0000_0000;
    assign w_ax = r_a ^ 64'h8000_0000_0000_0000;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.cmd)
                        CMD_PUSH: n_state = (r_sp == PW'(STACK_DEPTH)) ? S_OUT : S_WR;
                        CMD_POP:  n_state = (r_sp == '0) ? S_OUT : S_RDT;
                        CMD_DUP:  n_state = (r_sp == '0 || r_sp == PW'(STACK_DEPTH))
                                            ? S_OUT : S_RD1;
                        CMD_NEG:  n_state = (r_sp == '0) ? S_OUT : S_RD1;
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP:
                            n_state = (r_sp < PW'(2)) ? S_OUT : S_RD1;
                        default:  n_state = S_RDT;
                    endcase
                end
            end
            S_RD1:  n_state = (r_cmd == CMD_DUP || r_cmd == CMD_NEG) ? S_EXEC : S_RD2;
            S_RD2:  n_state = S_EXEC;
            S_EXEC: begin
                if (r_cmd == CMD_MUL) n_state = S_MUL;
                else if (r_cmd == CMD_DIV) n_state = (r_a == '0) ? S_OUT : S_DIV;
                else n_state = S_WR;
            end
            S_MUL:  n_state = r_mulph ? S_WR : S_MUL;
            S_DIV:  n_state = w_drsp.done ? S_WR : S_DIV;
            S_WR:   n_state = (r_cmd == CMD_SWAP) ? S_WR2 : S_OUT;
            S_WR2:  n_state = S_OUT;
            S_RDT:  n_state = S_OUT;
            S_OUT:  n_state = i_out_ready ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_sp     = r_sp;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_a      = r_a;
        n_b      = r_b;
        n_res    = r_res;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_status = r_status;
        n_top    = r_top;
        n_mulph  = 1'b0;
        w_raddr  = AW'(r_sp - PW'(1));
        w_we     = 1'b0;
        w_waddr  = AW'(r_sp - PW'(1));
        w_wdata  = r_res;
        w_dreq.start = 1'b0;
        w_dreq.num   = r_b;
        w_dreq.den   = r_a;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                n_cmd    = i_in.cmd;
                n_val    = i_in.push_value;
                n_status = ST_OK;
                if (i_in_valid) begin
                    case (i_in.cmd)
                        CMD_PUSH: if (r_sp == PW'(STACK_DEPTH)) n_status = ST_OVER;
                        CMD_POP, CMD_NEG: if (r_sp == '0) n_status = ST_UNDER;
                        CMD_DUP: begin
                            if (r_sp == '0) n_status = ST_UNDER;
                            else if (r_sp == PW'(STACK_DEPTH)) n_status = ST_OVER;
                        end
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP:
                            if (r_sp < PW'(2)) n_status = ST_UNDER;
                        default: ;
                    endcase
                    // pop drops first and reads the entry below the old top
                    if (i_in.cmd == CMD_POP) w_raddr = AW'(r_sp - PW'(2));
                    if (i_in.cmd == CMD_POP && r_sp != '0) n_sp = r_sp - PW'(1);
                end
            end
            S_RD1: begin
                // top arrives now; fetch b for two-operand commands
                n_a = r_rdata;
                if (r_cmd != CMD_DUP && r_cmd != CMD_NEG) w_raddr = AW'(r_sp - PW'(2));
            end
            S_RD2: w_raddr = AW'(r_sp - PW'(2));
            S_EXEC: begin
                if (r_cmd == CMD_DUP || r_cmd == CMD_NEG) n_a = r_rdata;
                else n_b = r_rdata;
                case (r_cmd)
                    CMD_ADD: n_res = r_rdata + r_a;
                    CMD_SUB: n_res = r_rdata - r_a;
                    CMD_CMP: n_res = 64'd0;
                    CMD_DUP: n_res = r_rdata;
                    CMD_NEG: n_res = 64'd0 - r_rdata;
                    CMD_SWAP: n_res = r_a;
                    default: n_res = r_res;
                endcase
                if (r_cmd == CMD_DIV && r_a == '0) n_status = ST_DIVZ;
                // cmp needs b, so the compare is decided in S_WR from the registered operands
            end
            S_MUL: begin
                // split product: low*low and cross terms, then their sum
                if (!r_mulph) begin
                    n_p0 = r_b[31:0] * r_a[31:0];
                    n_p1 = 64'(r_b[31:0] * r_a[63:32]) + 64'(r_b[63:32] * r_a[31:0]);
                    n_mulph = 1'b1;
                end else begin
                    n_res = r_p0 + {r_p1[31:0], 32'd0};
                end
            end
            S_DIV: begin
                if (w_drsp.done) n_res = w_drsp.quot;
            end
            S_WR: begin
                w_we = 1'b1;
                case (r_cmd)
                    CMD_PUSH: begin
                        w_waddr = AW'(r_sp);
                        w_wdata = r_val;
                        n_sp    = r_sp + PW'(1);
                        n_top   = r_val;
                    end
                    CMD_DUP: begin
                        w_waddr = AW'(r_sp);
                        n_sp    = r_sp + PW'(1);
                        n_top   = r_res;
                    end
                    CMD_NEG: n_top = r_res;
                    CMD_SWAP: begin
                        w_wdata = r_b;
                        n_top   = r_b;
                    end
                    default: begin
                        w_waddr = AW'(r_sp - PW'(2));
                        if (r_cmd == CMD_CMP)
                            w_wdata = (w_bx > w_ax) ? 64'd1 :
                                      (w_bx < w_ax) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
                        n_top = w_wdata;
                        n_sp  = r_sp - PW'(1);
                    end
                endcase
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_sp - PW'(2));
                w_wdata = r_a;
            end
            S_RDT: ;
            S_OUT: ;
            default: ;
        endcase
        if (r_state == S_EXEC && r_cmd == CMD_DIV && r_a != '0) w_dreq.start = 1'b1;
        if (r_state == S_EXEC && r_cmd == CMD_DIV) begin
            n_b = r_rdata;
            w_dreq.num = r_rdata;
        end
        if (r_state == S_RDT) n_top = (r_sp == '0) ? 64'd0 : r_rdata;
    end

    // stack_count is the 9-bit masked depth
    always_comb begin
        o_out.top_value   = (r_sp == '0) ? 64'sd0 : r_top;
        o_out.stack_count = 9'(r_sp);
        o_out.status      = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_mulph <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_mulph <= n_mulph;
        end
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_a      <= n_a;
        r_b      <= n_b;
        r_res    <= n_res;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_status <= n_status;
        r_top    <= n_top;
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH)) else $error("stack pointer past depth");
    a_err_keeps_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status != ST_OK) |-> $stable(r_sp))
        else $error("failed command moved the stack pointer");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_top)))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("accept while busy");

endmodule

[verif/tb_stack_machine_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_machine_alu - self-checking bench for the stack machine ALU
// Drives command words through a table of directed cases and then random
// command streams, predicts every result word from a local copy of the stack
// and compares it field by field under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_stack_machine_alu;
    import sma_pkg::*;

    localparam int          DEPTH     = 256;
    localparam int          LIMIT     = 1500000;
    localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out;

    stack_machine_alu #(.STACK_DEPTH(DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Predictor state: a private copy of the data stack.
    logic [63:0] model_stack [DEPTH];
    int          model_sp;
    t_out_word   expected_words [$];

    int  errors;
    int  cycle;
    int  send_idle_pct;   // percent of cycles the sender holds off
    int  recv_stall_pct;  // percent of cycles the receiver stalls
    bit  hold_off;        // long receiver stall in progress

    // Directed table: expected word typed in only where it is obvious.
    typedef struct {
        t_cmd        cmd;
        logic [63:0] value;
        bit          has_exp;
        t_out_word   exp;
    } t_row;

    t_row dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle >= LIMIT) begin
                $display("stack_machine_alu: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [63:0] quotient_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        nm = n[63] ? -n : n;
        dm = d[63] ? -d : d;
        q  = nm / dm;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // Advance the local stack by one command and return the result word.
    function automatic t_out_word execute_cmd(logic [3:0] code, logic [63:0] value);
        t_out_word   w;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] t;
        w.status = ST_OK;
        case (code)
            CMD_PUSH: begin
                if (model_sp >= DEPTH) w.status = ST_OVER;
                else begin
                    model_stack[model_sp] = value;
                    model_sp++;
                end
            end
            CMD_POP: begin
                if (model_sp < 1) w.status = ST_UNDER;
                else model_sp--;
            end
            CMD_SWAP: begin
                if (model_sp < 2) w.status = ST_UNDER;
                else begin
                    t = model_stack[model_sp-1];
                    model_stack[model_sp-1] = model_stack[model_sp-2];
                    model_stack[model_sp-2] = t;
                end
            end
            CMD_DUP: begin
                if (model_sp < 1) w.status = ST_UNDER;
                else if (model_sp >= DEPTH) w.status = ST_OVER;
                else begin
                    model_stack[model_sp] = model_stack[model_sp-1];
                    model_sp++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP: begin
                if (model_sp < 2) w.status = ST_UNDER;
                else begin
                    a = model_stack[model_sp-1];
                    b = model_stack[model_sp-2];
                    if (code == CMD_DIV && a == 64'd0) w.status = ST_DIVZ;
                    else begin
                        case (code)
                            CMD_ADD: r = b + a;
                            CMD_SUB: r = b - a;
                            CMD_MUL: r = b * a;
                            CMD_DIV: r = quotient_trunc(b, a);
                            default: begin
                                if ($signed(b) > $signed(a)) r = 64'd1;
                                else if ($signed(b) < $signed(a)) r = ALL_ONES;
                                else r = 64'd0;
                            end
                        endcase
                        model_sp--;
                        model_stack[model_sp-1] = r;
                    end
                end
            end
            CMD_NEG: begin
                if (model_sp < 1) w.status = ST_UNDER;
                else model_stack[model_sp-1] = -model_stack[model_sp-1];
            end
            default: ;  // unused codes do nothing
        endcase
        w.top_value   = (model_sp > 0) ? model_stack[model_sp-1] : 64'd0;
        w.stack_count = model_sp[8:0];
        return w;
    endfunction

    function automatic t_out_word make_word(logic [63:0] top, int count, t_status st);
        t_out_word w;
        w.top_value   = top;
        w.stack_count = count[8:0];
        w.status      = st;
        return w;
    endfunction

    function automatic void add_row(t_cmd c, logic [63:0] v, bit has, t_out_word e);
        t_row r;
        r.cmd = c; r.value = v; r.has_exp = has; r.exp = e;
        dir_rows.push_back(r);
    endfunction

    // Random operand: lean on extremes and small numbers so divides and
    // compares hit their corner cases often.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return ALL_ONES;
            3: return 64'd0;
            4: return 64'($signed($urandom_range(0, 20)) - 10);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one word: drop valid while idling, raise it at the falling edge
    // and hold until accepted; return at the next falling edge with valid high.
    task automatic send_word(logic [3:0] code, logic [63:0] value);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in.cmd        <= code;
        i_in.push_value <= value;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // Predict at acceptance so words stay in order.
        expected_words.push_back(execute_cmd(code, value));
        @(negedge i_clk);
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !hold_off &&
                           !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Checker: compare each accepted word with the oldest prediction.
    initial begin
        t_out_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out.top_value !== want.top_value) begin
                        $display("%0t: top_value expected %h actual %h",
                                 $time, want.top_value, o_out.top_value);
                        errors++;
                    end
                    if (o_out.stack_count !== want.stack_count) begin
                        $display("%0t: stack_count expected %0d actual %0d",
                                 $time, want.stack_count, o_out.stack_count);
                        errors++;
                    end
                    if (o_out.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_out.status);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic run_random(int count);
        int          k;
        logic [3:0]  code;
        for (k = 0; k < count; k++) begin
            // Keep the stack mostly shallow, but let it climb at times.
            if (model_sp < 2 && $urandom_range(0, 3) != 0) code = CMD_PUSH;
            else if ($urandom_range(0, 40) == 0) code = 4'($urandom_range(10, 15));
            else code = 4'($urandom_range(0, 9));
            send_word(code, pick_value());
        end
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int k;
        int guard;
        t_out_word none;
        none = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        model_sp = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;

        // Directed cases: underflow on empty, extremes, every command.
        add_row(CMD_POP,  64'd0, 1, make_word(64'd0, 0, ST_UNDER));
        add_row(CMD_DUP,  64'd0, 1, make_word(64'd0, 0, ST_UNDER));
        add_row(CMD_NEG,  64'd0, 1, make_word(64'd0, 0, ST_UNDER));
        add_row(CMD_PUSH, MOST_NEG, 1, make_word(MOST_NEG, 1, ST_OK));
        add_row(CMD_SWAP, 64'd0, 1, make_word(MOST_NEG, 1, ST_UNDER));
        add_row(CMD_ADD,  64'd0, 1, make_word(MOST_NEG, 1, ST_UNDER));
        add_row(CMD_NEG,  64'd0, 1, make_word(MOST_NEG, 1, ST_OK));
        add_row(CMD_PUSH, ALL_ONES, 1, make_word(ALL_ONES, 2, ST_OK));
        add_row(CMD_DIV,  64'd0, 1, make_word(MOST_NEG, 1, ST_OK));
        add_row(CMD_PUSH, 64'd0, 1, make_word(64'd0, 2, ST_OK));
        add_row(CMD_DIV,  64'd0, 1, make_word(64'd0, 2, ST_DIVZ));
        add_row(CMD_POP,  64'd0, 1, make_word(MOST_NEG, 1, ST_OK));
        add_row(CMD_PUSH, MOST_POS, 0, none);
        add_row(CMD_DUP,  64'd0, 0, none);
        add_row(CMD_ADD,  64'd0, 0, none);
        add_row(CMD_PUSH, 64'd7, 0, none);
        add_row(CMD_SWAP, 64'd0, 0, none);
        add_row(CMD_SUB,  64'd0, 0, none);
        add_row(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFD, 0, none);
        add_row(CMD_MUL,  64'd0, 0, none);
        add_row(CMD_PUSH, 64'd5, 0, none);
        add_row(CMD_CMP,  64'd0, 0, none);
        add_row(CMD_PUSH, 64'd5, 0, none);
        add_row(CMD_DIV,  64'd0, 0, none);
        add_row(t_cmd'(4'd15), 64'd0, 0, none);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].cmd, dir_rows[k].value);
            if (dir_rows[k].has_exp && expected_words[$] !== dir_rows[k].exp) begin
                $display("%0t: table row %0d expected %h actual %h",
                         $time, k, dir_rows[k].exp, expected_words[$]);
                errors++;
            end
        end
        drain();

        // Fill to the top, hit overflow on push and dup, then empty out.
        for (k = model_sp; k < DEPTH; k++) send_word(CMD_PUSH, pick_value());
        send_word(CMD_PUSH, MOST_POS);
        send_word(CMD_DUP, 64'd0);
        while (model_sp > 0) send_word(CMD_POP, 64'd0);

        // Random phases with different idling.
        run_random(250);
        send_idle_pct = 76; run_random(200);
        send_idle_pct = 0;  recv_stall_pct = 76; run_random(200);
        send_idle_pct = 20; recv_stall_pct = 20; run_random(200);

        // Long receiver hold-off while the sender keeps offering words.
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                guard = 0;
                while (guard < 400) begin
                    @(posedge i_clk);
                    guard++;
                end
                hold_off = 1'b0;
            end
            run_random(20);
        join
        run_random(270);

        @(negedge i_clk);
        drain();
        if (errors == 0) $display("stack_machine_alu: match");
        else $display("stack_machine_alu: mismatch");
        $finish;
    end

endmodule

[files.f]
hdl/sma_pkg.sv
hdl/sma_div.sv
hdl/stack_machine_alu.sv
verif/tb_stack_machine_alu.sv
